// ----- sv/wmm_pkg.sv -----
`timescale 1ns / 1ps

package wmm_pkg;

   localparam int MAX_WORD_LEN = 8;
   localparam int MAX_WORDS    = 16;
   localparam int NUM_PHASES   = MAX_WORD_LEN;

   localparam int SYM_W  = 8;
   localparam int WORD_W = SYM_W * MAX_WORD_LEN;
   localparam int WL_W   = 4;
   localparam int POS_W  = 24;
   localparam int ID_W   = 4;
   localparam int PH_W   = 3;
   localparam int CNT_W  = 5;
   localparam int FILL_W = 3;
   localparam int SLOT_W = PH_W + ID_W;
   localparam int SLOTS  = NUM_PHASES * MAX_WORDS;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [CNT_W-1:0] WORDS_FULL = CNT_W'(MAX_WORDS);
   localparam logic [WL_W-1:0]  WL_MAX = WL_W'(MAX_WORD_LEN);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_LOAD_NEW,
      OP_TEXT,
      OP_TEXT_NEW
   } op_type;

   typedef enum logic {
      KIND_MATCH    = 1'b0,
      KIND_OVERFLOW = 1'b1
   } kind_type;

   typedef struct packed {
      logic             valid;
      op_type           op;
      logic [SYM_W-1:0] sym;
   } item_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } q_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } eng_status_type;

   // bytes below word_len kept, the rest zeroed
   function automatic logic [WORD_W-1:0] byte_mask(input logic [WL_W-1:0] wl);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
         if (WL_W'(k) < wl) begin
            m[SYM_W*k +: SYM_W] = {SYM_W{1'b1}};
         end
      end
      return m;
   endfunction

endpackage

// ----- sv/wmm_front.sv -----
`timescale 1ns / 1ps

module wmm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [7:0]                req_symbol,
   input  logic                      req_begin_req,
   input  logic                      pop,
   output wmm_pkg::item_type         head,
   output wmm_pkg::q_status_type     status
);

   wmm_pkg::item_type              q_ff [wmm_pkg::QDEPTH];
   logic [wmm_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [wmm_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [wmm_pkg::QCNT_W-1:0]     count_ff;
   wmm_pkg::item_type              item_in;
   logic                           push;
   logic                           take;

   // classify: dictionary or text, fresh start or continuation
   always_comb begin
      item_in.valid = 1'b1;
      item_in.sym   = req_symbol;
      if (req_command) begin
         item_in.op = req_begin_req ? wmm_pkg::OP_TEXT_NEW : wmm_pkg::OP_TEXT;
      end else begin
         item_in.op = req_begin_req ? wmm_pkg::OP_LOAD_NEW : wmm_pkg::OP_LOAD;
      end
   end

   assign req_stall = (count_ff == wmm_pkg::QCNT_W'(wmm_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign take      = pop && (count_ff != '0);

   always_comb begin
      head       = q_ff[rd_ptr_ff];
      head.valid = (count_ff != '0);
   end

   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !take) begin
            count_ff <= count_ff + 1'b1;
         end else if (take && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/wmm_back.sv -----
`timescale 1ns / 1ps

module wmm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [wmm_pkg::WL_W-1:0]           word_len,
   input  logic                               cfg_clear,
   input  wmm_pkg::item_type                  head,
   output logic                               pop,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_kind,
   output logic [23:0]                        rsp_match_start,
   output wmm_pkg::eng_status_type            status
);

   typedef enum logic [3:0] {
      S_IDLE, S_DLOOK, S_TLOOK, S_POP_A, S_POP_B, S_POP_C, S_INS_A, S_INS_B, S_CHECK
   } state_type;

   typedef enum logic [1:0] {
      CTX_PRE, CTX_EXCESS, CTX_MATCH
   } ctx_type;

   localparam int WW = wmm_pkg::WORD_W;
   localparam int PW = wmm_pkg::POS_W;
   localparam int CW = wmm_pkg::CNT_W;
   localparam int IW = wmm_pkg::ID_W;
   localparam int HW = wmm_pkg::PH_W;
   localparam int AW = wmm_pkg::SLOT_W;

   state_type                  state_ff;
   ctx_type                    ctx_ff;

   // dictionary
   logic [WW-1:0]              dict_word_ff [wmm_pkg::MAX_WORDS];
   logic [CW-1:0]              need_ff [wmm_pkg::MAX_WORDS];
   logic [CW-1:0]              distinct_ff;
   logic [CW-1:0]              total_ff;
   logic [WW-1:0]              load_buf_ff;
   logic [wmm_pkg::FILL_W-1:0] fill_ff;

   // text
   logic [WW-1:0]              shift_ff;
   logic [PW-1:0]              pos_ff;
   logic [HW-1:0]              phase_ff;

   // per-phase window
   logic [IW-1:0]              head_ff [wmm_pkg::NUM_PHASES];
   logic [CW-1:0]              wtot_ff [wmm_pkg::NUM_PHASES];
   logic [PW-1:0]              left_ff [wmm_pkg::NUM_PHASES];
   logic [wmm_pkg::SLOTS-1:0]  seen_vld_ff;

   // current word
   logic [HW-1:0]              cur_ph_ff;
   logic [IW-1:0]              cur_id_ff;
   logic [CW-1:0]              cur_seen_ff;
   logic [CW-1:0]              need_id_ff;
   logic [IW-1:0]              pop_id_ff;

   // memories
   logic [CW-1:0]              seen_mem [wmm_pkg::SLOTS];
   logic [IW-1:0]              wid_mem [wmm_pkg::SLOTS];
   logic [CW-1:0]              seen_rd_ff;
   logic                       seen_rdv_ff;
   logic [IW-1:0]              wid_rd_ff;
   logic                       seen_we;
   logic [AW-1:0]              seen_waddr;
   logic [CW-1:0]              seen_wdata;
   logic [AW-1:0]              seen_raddr;
   logic                       wid_we;
   logic [AW-1:0]              wid_waddr;
   logic [AW-1:0]              wid_raddr;

   // output register
   logic                       rsp_valid_ff;
   logic                       rsp_kind_ff;
   logic [PW-1:0]              rsp_start_ff;

   logic                       out_free;
   logic                       is_text;
   logic                       is_new;
   logic [wmm_pkg::FILL_W-1:0] fill_eff;
   logic [wmm_pkg::WL_W-1:0]   fill_inc;
   logic                       dict_done;
   logic [PW-1:0]              pos_eff;
   logic [PW-1:0]              pos_new;
   logic [HW-1:0]              phase_eff;
   logic [HW-1:0]              wl_m1;
   logic                       word_ready;
   logic                       clr_text;
   logic                       clr_dict;
   logic [wmm_pkg::WL_W-1:0]   sh_bytes;
   logic [WW-1:0]              mask;
   logic [WW-1:0]              cand;
   logic [wmm_pkg::MAX_WORDS-1:0] hit_vec;
   logic                       lk_hit;
   logic [IW-1:0]              lk_id;
   logic [IW-1:0]              cur_head;
   logic [CW-1:0]              cur_tot;
   logic [CW-1:0]              seen_dat;
   logic [CW-1:0]              seen_dec;
   logic [PW:0]                left_sum;
   logic [PW-1:0]              left_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && head.valid && out_free;
   assign is_text  = (head.op == wmm_pkg::OP_TEXT) || (head.op == wmm_pkg::OP_TEXT_NEW);
   assign is_new   = (head.op == wmm_pkg::OP_LOAD_NEW) || (head.op == wmm_pkg::OP_TEXT_NEW);

   assign clr_dict = cfg_clear || (pop && (head.op == wmm_pkg::OP_LOAD_NEW));
   assign clr_text = cfg_clear || (pop && (!is_text || is_new));

   // load side
   assign fill_eff  = is_new ? '0 : fill_ff;
   assign fill_inc  = wmm_pkg::WL_W'(fill_eff) + 1'b1;
   assign dict_done = (fill_inc >= word_len);

   // text side
   assign pos_eff    = is_new ? '0 : pos_ff;
   assign phase_eff  = is_new ? '0 : phase_ff;
   assign pos_new    = pos_eff + 1'b1;
   assign word_ready = (pos_new >= PW'(word_len));
   assign wl_m1      = HW'(word_len - 1'b1);

   // shared dictionary lookup
   assign mask     = wmm_pkg::byte_mask(word_len);
   assign sh_bytes = wmm_pkg::WL_MAX - word_len;
   assign cand     = (state_ff == S_DLOOK) ? (load_buf_ff & mask)
                                           : (shift_ff >> {sh_bytes, 3'b000});

   always_comb begin
      for (int i = 0; i < wmm_pkg::MAX_WORDS; i++) begin
         hit_vec[i] = (dict_word_ff[i] == cand) && (CW'(i) < distinct_ff);
      end
      lk_id = '0;
      for (int i = wmm_pkg::MAX_WORDS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            lk_id = IW'(i);
         end
      end
   end
   assign lk_hit = |hit_vec;

   assign cur_head = head_ff[cur_ph_ff];
   assign cur_tot  = wtot_ff[cur_ph_ff];
   assign seen_dat = seen_rdv_ff ? seen_rd_ff : '0;
   assign seen_dec = (seen_dat == '0) ? '0 : seen_dat - 1'b1;

   // saturating advance of the window's left edge
   assign left_sum  = {1'b0, left_ff[cur_ph_ff]} + (PW + 1)'(word_len);
   assign left_next = (left_sum > {1'b0, wmm_pkg::POS_MAX}) ? wmm_pkg::POS_MAX
                                                           : left_sum[PW-1:0];

   // memory port control
   assign wid_raddr  = {cur_ph_ff, cur_head};
   assign wid_we     = (state_ff == S_INS_A);
   assign wid_waddr  = {cur_ph_ff, IW'(cur_head + cur_tot[IW-1:0])};
   assign seen_raddr = (state_ff == S_POP_B) ? {cur_ph_ff, wid_rd_ff} : {cur_ph_ff, cur_id_ff};
   assign seen_we    = (state_ff == S_POP_C) || (state_ff == S_INS_B);
   assign seen_waddr = (state_ff == S_POP_C) ? {cur_ph_ff, pop_id_ff} : {cur_ph_ff, cur_id_ff};
   assign seen_wdata = (state_ff == S_POP_C) ? seen_dec : seen_dat + 1'b1;

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      seen_rd_ff <= seen_mem[seen_raddr];
   end

   always_ff @(posedge clock) begin
      if (wid_we) begin
         wid_mem[wid_waddr] <= cur_id_ff;
      end
      wid_rd_ff <= wid_mem[wid_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctx_ff       <= CTX_PRE;
         distinct_ff  <= '0;
         total_ff     <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         phase_ff     <= '0;
         seen_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < wmm_pkg::NUM_PHASES; p++) begin
            head_ff[p] <= '0;
            wtot_ff[p] <= '0;
            left_ff[p] <= PW'(p);
         end
         for (int i = 0; i < wmm_pkg::MAX_WORDS; i++) begin
            need_ff[i] <= '0;
         end
      end else begin
         seen_rdv_ff <= seen_vld_ff[seen_raddr];
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (seen_we) begin
            seen_vld_ff[seen_waddr] <= 1'b1;
         end
         if (clr_dict) begin
            distinct_ff <= '0;
            total_ff    <= '0;
            fill_ff     <= '0;
            for (int i = 0; i < wmm_pkg::MAX_WORDS; i++) begin
               need_ff[i] <= '0;
            end
         end
         if (clr_text) begin
            pos_ff      <= '0;
            phase_ff    <= '0;
            seen_vld_ff <= '0;
            for (int p = 0; p < wmm_pkg::NUM_PHASES; p++) begin
               head_ff[p] <= '0;
               wtot_ff[p] <= '0;
               left_ff[p] <= PW'(p);
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  if (!is_text) begin
                     load_buf_ff[fill_eff*8 +: 8] <= head.sym;
                     if (dict_done) begin
                        fill_ff  <= '0;
                        state_ff <= S_DLOOK;
                     end else begin
                        fill_ff <= fill_inc[wmm_pkg::FILL_W-1:0];
                     end
                  end else if (pos_eff != wmm_pkg::POS_MAX) begin
                     shift_ff <= {head.sym, shift_ff[WW-1:8]};
                     pos_ff   <= pos_new;
                     if (word_ready) begin
                        cur_ph_ff <= phase_eff;
                        phase_ff  <= (phase_eff == wl_m1) ? '0 : phase_eff + 1'b1;
                        state_ff  <= S_TLOOK;
                     end
                  end
               end
            end
            S_DLOOK: begin
               if (total_ff >= wmm_pkg::WORDS_FULL) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= wmm_pkg::KIND_OVERFLOW;
                  rsp_start_ff <= '0;
               end else begin
                  if (lk_hit) begin
                     need_ff[lk_id] <= need_ff[lk_id] + 1'b1;
                  end else begin
                     dict_word_ff[distinct_ff[IW-1:0]] <= cand;
                     need_ff[distinct_ff[IW-1:0]]      <= CW'(1);
                     distinct_ff                       <= distinct_ff + 1'b1;
                  end
                  total_ff <= total_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_TLOOK: begin
               if (!lk_hit) begin
                  // unknown word restarts this alignment's window
                  for (int k = 0; k < wmm_pkg::MAX_WORDS; k++) begin
                     seen_vld_ff[{cur_ph_ff, IW'(k)}] <= 1'b0;
                  end
                  head_ff[cur_ph_ff] <= '0;
                  wtot_ff[cur_ph_ff] <= '0;
                  left_ff[cur_ph_ff] <= pos_ff;
                  state_ff           <= S_IDLE;
               end else begin
                  cur_id_ff  <= lk_id;
                  need_id_ff <= need_ff[lk_id];
                  if (cur_tot >= wmm_pkg::WORDS_FULL) begin
                     ctx_ff   <= CTX_PRE;
                     state_ff <= S_POP_A;
                  end else begin
                     state_ff <= S_INS_A;
                  end
               end
            end
            S_POP_A: begin
               state_ff <= S_POP_B;
            end
            S_POP_B: begin
               pop_id_ff <= wid_rd_ff;
               state_ff  <= S_POP_C;
            end
            S_POP_C: begin
               if (pop_id_ff == cur_id_ff) begin
                  cur_seen_ff <= seen_dec;
               end
               head_ff[cur_ph_ff] <= cur_head + 1'b1;
               wtot_ff[cur_ph_ff] <= cur_tot - 1'b1;
               left_ff[cur_ph_ff] <= left_next;
               case (ctx_ff)
                  CTX_PRE:    state_ff <= S_INS_A;
                  CTX_EXCESS: state_ff <= S_CHECK;
                  default:    state_ff <= S_IDLE;
               endcase
            end
            S_INS_A: begin
               state_ff <= S_INS_B;
            end
            S_INS_B: begin
               cur_seen_ff        <= seen_dat + 1'b1;
               wtot_ff[cur_ph_ff] <= cur_tot + 1'b1;
               state_ff           <= S_CHECK;
            end
            S_CHECK: begin
               if ((cur_seen_ff > need_id_ff) && (cur_tot != '0)) begin
                  ctx_ff   <= CTX_EXCESS;
                  state_ff <= S_POP_A;
               end else if ((total_ff != '0) && (cur_tot == total_ff)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= wmm_pkg::KIND_MATCH;
                  rsp_start_ff <= left_ff[cur_ph_ff];
                  ctx_ff       <= CTX_MATCH;
                  state_ff     <= S_POP_A;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (cfg_clear) begin
            state_ff <= S_IDLE;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_match_start = rsp_start_ff;
   assign status.busy     = (state_ff != S_IDLE);
   assign status.pop      = pop;

endmodule

// ----- sv/word_multiset_window_matcher.sv -----
`timescale 1ns / 1ps
// Multiset-of-words window matcher.
// Program word_len (register 0, 1..8, written at APB address 0) while idle;
// the write clears dictionary and text. Then send dictionary words on the
// req channel (command 0, every word_len bytes form a word; begin_req
// starts a new dictionary), then text bytes (command 1, begin_req starts a
// new text). The rsp channel carries one word per match: kind 0 with the
// start position, or kind 1 when a dictionary word exceeds 16 words.
// A four-entry queue takes req words while the engine works, so req_stall
// only rises when the queue is full.
// Engine states per item: a byte that does not finish a word uses S_IDLE
// alone; a finished dictionary word adds S_DLOOK; a text word adds S_TLOOK,
// and a known text word then S_INS_A, S_INS_B and S_CHECK, plus S_POP_A,
// S_POP_B and S_POP_C when a full window first drops its oldest word, the
// pop states and S_CHECK again for every surplus copy dropped after the
// insert, and the pop states for the slide after a match. rsp_valid is set
// in S_DLOOK for an overflow, in S_CHECK for a match; queue waits delay it.
// The engine starts an item only when the rsp register is empty or being
// taken, so a stalled rsp blocks the engine and then the queue.
// Reset (synchronous) clears the control and valid state; word_len returns to 1.
module word_multiset_window_matcher (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_symbol,
   input  logic        req_begin_req,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [23:0] rsp_match_start,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [wmm_pkg::WL_W-1:0]  wl_ff;
   logic [wmm_pkg::WL_W-1:0]  wl_in;
   logic [wmm_pkg::WL_W-1:0]  wr_val;
   logic                      cfg_wr;
   wmm_pkg::item_type         q_head;
   wmm_pkg::q_status_type     fr_st;
   wmm_pkg::eng_status_type   eng_st;
   logic                      eng_pop;

   // register 0 is the only one; addresses at 4 and up are ignored
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? {28'd0, wl_ff} : 32'd0;

   // clamp written word length to 1..MAX_WORD_LEN
   assign wr_val = pwdata[3:0];
   always_comb begin
      if (wr_val == '0) begin
         wl_in = wmm_pkg::WL_W'(1);
      end else if (wr_val > wmm_pkg::WL_MAX) begin
         wl_in = wmm_pkg::WL_MAX;
      end else begin
         wl_in = wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= wmm_pkg::WL_W'(1);
      end else if (cfg_wr) begin
         wl_ff <= wl_in;
      end
   end

   wmm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_symbol    (req_symbol),
      .req_begin_req (req_begin_req),
      .pop           (eng_pop),
      .head          (q_head),
      .status        (fr_st)
   );

   wmm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .word_len        (wl_ff),
      .cfg_clear       (cfg_wr),
      .head            (q_head),
      .pop             (eng_pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_match_start (rsp_match_start),
      .status          (eng_st)
   );

`ifndef SYNTHESIS
   a_ovf_zero_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == wmm_pkg::KIND_OVERFLOW)) |-> (rsp_match_start == '0))
      else $error("overflow result carries a nonzero start");

   a_rsp_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(eng_st.busy))
      else $error("result appeared without engine activity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      eng_st.pop |-> (fr_st.count != '0))
      else $error("engine took a word from an empty queue");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fr_st.count <= wmm_pkg::QCNT_W'(wmm_pkg::QDEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

// ----- test/wmm_checker.sv -----
`timescale 1ns / 1ps

module wmm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_symbol,
   input  logic        req_begin_req,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_kind,
   input  logic [23:0] rsp_match_start,
   input  logic        cfg_write,
   input  logic [31:0] cfg_data,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      wmm_pkg::kind_type                kind;
      logic [wmm_pkg::POS_W-1:0]        start;
   } result_type;

   result_type              expected_q[$];
   int unsigned             wlen;
   logic [7:0]              dwords[wmm_pkg::MAX_WORDS][wmm_pkg::MAX_WORD_LEN];
   int unsigned             need[wmm_pkg::MAX_WORDS];
   int unsigned             n_distinct, n_total, fill;
   logic [7:0]              lbuf[wmm_pkg::MAX_WORD_LEN];
   logic [7:0]              tshift[wmm_pkg::MAX_WORD_LEN];
   int unsigned             tpos;
   int unsigned             seen[wmm_pkg::MAX_WORD_LEN][wmm_pkg::MAX_WORDS];
   int unsigned             wids[wmm_pkg::MAX_WORD_LEN][wmm_pkg::MAX_WORDS];
   int unsigned             head[wmm_pkg::MAX_WORD_LEN];
   int unsigned             wtot[wmm_pkg::MAX_WORD_LEN];
   int unsigned             left[wmm_pkg::MAX_WORD_LEN];

   assign pending = expected_q.size();

   function automatic void clear_phase(int unsigned ph, int unsigned l);
      for (int i = 0; i < wmm_pkg::MAX_WORDS; i++) seen[ph][i] = 0;
      head[ph] = 0;
      wtot[ph] = 0;
      left[ph] = l;
   endfunction

   function automatic void clear_text();
      for (int p = 0; p < wmm_pkg::MAX_WORD_LEN; p++) begin
         tshift[p] = 0;
         for (int i = 0; i < wmm_pkg::MAX_WORDS; i++) wids[p][i] = 0;
         clear_phase(p, p);
      end
      tpos = 0;
   endfunction

   function automatic void clear_dict();
      for (int i = 0; i < wmm_pkg::MAX_WORDS; i++) begin
         need[i] = 0;
         for (int k = 0; k < wmm_pkg::MAX_WORD_LEN; k++) dwords[i][k] = 0;
      end
      for (int k = 0; k < wmm_pkg::MAX_WORD_LEN; k++) lbuf[k] = 0;
      n_distinct = 0;
      n_total = 0;
      fill = 0;
   endfunction

   // word lookup; text words sit at the top of the shift history
   function automatic int lookup(logic [7:0] w[wmm_pkg::MAX_WORD_LEN], int unsigned off);
      bit same;
      for (int i = 0; i < n_distinct && i < wmm_pkg::MAX_WORDS; i++) begin
         same = 1;
         for (int k = 0; k < wlen; k++)
            if (dwords[i][k] != w[off + k]) same = 0;
         if (same) return i;
      end
      return -1;
   endfunction

   function automatic void drop_left(int unsigned ph);
      int unsigned id, nl;
      if (wtot[ph] == 0) return;
      id = wids[ph][head[ph] % wmm_pkg::MAX_WORDS] % wmm_pkg::MAX_WORDS;
      if (seen[ph][id] > 0) seen[ph][id]--;
      head[ph] = (head[ph] + 1) % wmm_pkg::MAX_WORDS;
      wtot[ph]--;
      nl = left[ph] + wlen;
      left[ph] = nl > wmm_pkg::POS_MAX ? wmm_pkg::POS_MAX : nl;
   endfunction

   function automatic void predict_word(logic cmd, logic [7:0] sym, logic beg);
      result_type r;
      int id;
      int unsigned ph, slot;
      if (!cmd) begin
         if (beg) clear_dict();
         clear_text();
         lbuf[fill % wmm_pkg::MAX_WORD_LEN] = sym;
         fill++;
         if (fill < wlen) return;
         fill = 0;
         if (n_total >= wmm_pkg::MAX_WORDS) begin
            r.kind = wmm_pkg::KIND_OVERFLOW;
            r.start = '0;
            expected_q.push_back(r);
            return;
         end
         id = lookup(lbuf, 0);
         if (id < 0) begin
            id = n_distinct;
            for (int k = 0; k < wlen; k++) dwords[id][k] = lbuf[k];
            need[id] = 0;
            n_distinct++;
         end
         need[id]++;
         n_total++;
         return;
      end
      if (beg) clear_text();
      if (tpos >= wmm_pkg::POS_MAX) return;
      for (int k = 0; k < wmm_pkg::MAX_WORD_LEN - 1; k++) tshift[k] = tshift[k+1];
      tshift[wmm_pkg::MAX_WORD_LEN-1] = sym;
      tpos++;
      if (tpos < wlen) return;
      ph = (tpos - wlen) % wlen;
      id = lookup(tshift, wmm_pkg::MAX_WORD_LEN - wlen);
      if (id < 0) begin
         clear_phase(ph, tpos);
         return;
      end
      if (wtot[ph] >= wmm_pkg::MAX_WORDS) drop_left(ph);
      slot = (head[ph] + wtot[ph]) % wmm_pkg::MAX_WORDS;
      wids[ph][slot] = id;
      seen[ph][id]++;
      wtot[ph]++;
      while (seen[ph][id] > need[id] && wtot[ph] > 0) drop_left(ph);
      if (n_total > 0 && wtot[ph] == n_total) begin
         r.kind = wmm_pkg::KIND_MATCH;
         r.start = wmm_pkg::POS_W'(left[ph]);
         expected_q.push_back(r);
         drop_left(ph);
      end
   endfunction

   always @(posedge clock) begin
      result_type e;
      int unsigned v;
      if (reset) begin
         wlen = 1;
         clear_dict();
         clear_text();
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (cfg_write) begin
            v = 32'(cfg_data[3:0]);
            wlen = v < 1 ? 1 : (v > wmm_pkg::MAX_WORD_LEN ? wmm_pkg::MAX_WORD_LEN : v);
            clear_dict();
            clear_text();
         end
         if (req_valid && !req_stall)
            predict_word(req_command, req_symbol, req_begin_req);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result kind %0d start %0d", rsp_kind, rsp_match_start);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d actual %0d", e.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_match_start !== e.start) begin
                  $error("match_start: expected %0d actual %0d", e.start, rsp_match_start);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- test/tb_word_multiset_window_matcher.sv -----
`timescale 1ns / 1ps

module tb_word_multiset_window_matcher;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_command = 0;
   logic [7:0]  req_symbol = 0;
   logic        req_begin_req = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_kind;
   logic [23:0] rsp_match_start;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count, pending, cycles;
   bit          calm;       // no idling on either side while set
   logic [7:0]  vocab[4][wmm_pkg::MAX_WORD_LEN];
   int          wl_now;

   word_multiset_window_matcher DUT (.*);

   // checker sees the register write at the access edge
   wmm_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_symbol,
      .req_begin_req, .rsp_valid, .rsp_stall, .rsp_kind, .rsp_match_start,
      .cfg_write(psel && penable && pwrite && pready && paddr == 3'd0),
      .cfg_data(pwdata), .fail_count, .pending);

   initial forever #2 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_word_multiset_window_matcher: errors");
         $finish;
      end
   end

   // receiver stalls at random, about 27 in 100, except in calm stretches
   always @(negedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);

   task automatic csr_write(input logic [31:0] d);
      @(negedge clock);
      psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= d; penable <= 0;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // one word on req: random gap, then hold until taken
   task automatic send_word(input logic cmd, input logic [7:0] sym, input logic beg);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_symbol <= sym;
      req_begin_req <= beg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // fresh small vocabulary for the current word length
   task automatic pick_vocab();
      for (int v = 0; v < 4; v++)
         for (int k = 0; k < wmm_pkg::MAX_WORD_LEN; k++)
            vocab[v][k] = (k == 0 && $urandom_range(3) == 0) ? 8'hFF
                                                             : 8'($urandom_range(3)) + 8'h61;
   endtask

   // random dictionary of n words from the vocabulary
   task automatic load_dict(input int n);
      for (int w = 0; w < n; w++) begin
         int v;
         v = $urandom_range(3);
         for (int k = 0; k < wl_now; k++)
            send_word(0, vocab[v][k], w == 0 && k == 0);
      end
   endtask

   // text mostly made of vocabulary words, with stray bytes mixed in
   task automatic stream_text(input int words);
      for (int w = 0; w < words; w++) begin
         int v;
         v = $urandom_range(3);
         if ($urandom_range(9) == 0)
            send_word(1, 8'($urandom_range(255)), w == 0);
         else
            for (int k = 0; k < wl_now; k++)
               send_word(1, vocab[v][k], w == 0 && k == 0);
      end
   endtask

   initial begin
      int sent;
      cycles = 0;
      calm = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: word_len 1 at reset, byte extremes
      wl_now = 1;
      send_word(0, 8'h00, 1);
      send_word(0, 8'hFF, 0);
      send_word(1, 8'hFF, 1);
      send_word(1, 8'h00, 0);
      send_word(1, 8'h00, 0);
      send_word(1, 8'hFF, 0);
      send_word(1, 8'h55, 0);
      // empty dictionary: text never matches
      go_idle();
      csr_write(32'd0);   // 0 taken as 1
      send_word(1, 8'hAA, 1);
      send_word(1, 8'hAA, 0);
      // overflow: 17 words of length 1
      for (int i = 0; i < 17; i++) send_word(0, i[7:0], i == 0);
      // dictionary byte mid-text resets text state
      send_word(1, 8'h00, 1);
      send_word(0, 8'h01, 0);
      send_word(1, 8'h01, 0);
      go_idle();
      csr_write(32'hF);   // above max, clamps to 8
      wl_now = wmm_pkg::MAX_WORD_LEN;
      pick_vocab();
      load_dict(2);
      send_word(0, 8'h61, 0);   // partial word left behind
      stream_text(4);

      sent = 0;
      // random phases over several word lengths, extremes included
      for (int phase = 0; sent < 900; phase++) begin
         int nd, nt;
         go_idle();
         case (phase % 5)
            0: wl_now = 1;
            1: wl_now = wmm_pkg::MAX_WORD_LEN;
            default: wl_now = $urandom_range(1, wmm_pkg::MAX_WORD_LEN);
         endcase
         csr_write({4'($urandom_range(15)), 28'(wl_now)});
         pick_vocab();
         calm = (phase == 3);
         nd = (phase % 7 == 6) ? 17 : $urandom_range(1, 5);
         nt = $urandom_range(8, 30) / ((wl_now + 1) / 2);
         load_dict(nd);
         stream_text(nt);
         sent += nd * wl_now + nt * wl_now;
         calm = 0;
      end

      go_idle();
      if (fail_count == 0)
         $display("tb_word_multiset_window_matcher: clean");
      else
         $display("tb_word_multiset_window_matcher: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/wmm_pkg.sv
sv/wmm_front.sv
sv/wmm_back.sv
sv/word_multiset_window_matcher.sv
test/wmm_checker.sv
test/tb_word_multiset_window_matcher.sv
